// File: sv/brsm_pkg.sv
// ----------------------------------------------------------------------------
// brsm_pkg: shared types and constants of the block RMS level meter
// Payload structs, controller states, command and status groups and the
// fixed widths of the meter arithmetic.
// ----------------------------------------------------------------------------
package brsm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int MAG_W    = 24;
  localparam int SQ_W     = 47;
  localparam int SUM_W    = 59;
  localparam int LEVEL_W  = 16;
  localparam int ALPHA_W  = 17;
  localparam int RAD_W    = 46;
  localparam int ROOT_W   = 23;
  localparam int REM_W    = 24;
  localparam int PROD_W   = 33;
  localparam int STEP_W   = 6;
  localparam int DIV_STEPS  = 59;
  localparam int ROOT_STEPS = 23;

  localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0]  ROOT_LAST   = STEP_W'(ROOT_STEPS - 1);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd58982;
  localparam logic [PROD_W-1:0]  ROUND_HALF  = 33'd32768;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'hFFFF;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_block;
  } in_t;

  typedef struct packed {
    logic               channel_res;
    logic [LEVEL_W-1:0] level;
    logic               block_overflowed;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_LOAD_DIV,
    ST_DIV,
    ST_LOAD_ROOT,
    ST_ROOT,
    ST_MUL_NEW,
    ST_MUL_PREV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clear_all;
    logic square;
    logic accum;
    logic div_load;
    logic div_step;
    logic root_load;
    logic root_step;
    logic mul_new;
    logic mul_prev;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_req;
    logic ch_ok;
    logic last;
  } status_t;

endpackage

// File: sv/brsm_ctrl.sv
// ----------------------------------------------------------------------------
// brsm_ctrl: meter sequencer
// Steps each sample request through square and accumulate, and a closed block
// through the serial divide, the serial root, smoothing and result hand-off.
// ----------------------------------------------------------------------------
module brsm_ctrl
  import brsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sts.clear_req) begin
          cmd.clear_all = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!sts.ch_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.square = 1'b1;
          state_nxt  = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = sts.last ? ST_LOAD_DIV : ST_IDLE;
      end
      ST_LOAD_DIV: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_LOAD_ROOT;
        end
      end
      ST_LOAD_ROOT: begin
        cmd.root_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == ROOT_LAST) begin
          state_nxt = ST_MUL_NEW;
        end
      end
      ST_MUL_NEW: begin
        cmd.mul_new = 1'b1;
        state_nxt   = ST_MUL_PREV;
      end
      ST_MUL_PREV: begin
        cmd.mul_prev = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> step_r <= DIV_LAST)
    else $error("divide step count overran");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROOT |-> step_r <= ROOT_LAST)
    else $error("root step count overran");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && (!out_valid_r || out_ready))
      |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not presented");

endmodule

// File: sv/brsm_dp.sv
// ----------------------------------------------------------------------------
// brsm_dp: meter datapath
// Per-channel accumulators, squarer, bit-serial divider, bit-serial square
// root, smoothing multiplier and the result register.
// ----------------------------------------------------------------------------
module brsm_dp
  import brsm_pkg::*;
#(
  parameter int CHANNELS  = 2,
  parameter int MAX_BLOCK = 4096
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  in_t                in_data,
  input  logic               cfg_valid,
  input  logic [ALPHA_W-1:0] cfg_data,
  input  cmd_t               cmd,
  output status_t            sts,
  output out_t               out_data
);

  localparam int CW  = $clog2(MAX_BLOCK + 1);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCK);

  logic [ALPHA_W-1:0] alpha_r;
  logic [SUM_W-1:0]   sum_r    [CHANNELS];
  logic [CW-1:0]      count_r  [CHANNELS];
  logic               ovf_r    [CHANNELS];
  logic [LEVEL_W-1:0] smooth_r [CHANNELS];

  in_t                in_r;
  logic [SQ_W-1:0]    sq_r;
  logic [SUM_W-1:0]   quo_r;
  logic [CW-1:0]      rem_r;
  logic [CW-1:0]      divisor_r;
  logic [RAD_W-1:0]   rad_r;
  logic [REM_W-1:0]   rrem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [PROD_W-1:0]  p_new_r;
  logic [PROD_W-1:0]  p_prev_r;
  out_t               out_r;

  logic [CHW-1:0]     ch_idx;
  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W-1:0] sq_full;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_new;
  logic [CW:0]        div_trial;
  logic               div_ge;
  logic [CW:0]        div_diff;
  logic [REM_W+1:0]   root_in;
  logic [REM_W+1:0]   root_trial;
  logic               root_ge;
  logic [REM_W+1:0]   root_diff;
  logic [LEVEL_W-1:0] rms;
  logic [ALPHA_W-1:0] alpha_eff;
  logic [ALPHA_W-1:0] alpha_inv;
  logic [PROD_W-1:0]  level_sum;

  assign ch_idx = CHW'(in_r.channel);

  assign sts.clear_req = (in_r.mode == MODE_CLEAR);
  assign sts.ch_ok     = (int'(in_r.channel) < CHANNELS);
  assign sts.last      = in_r.last_in_block;

  assign mag     = in_r.sample[SAMPLE_W-1] ? MAG_W'(-in_r.sample) : MAG_W'(in_r.sample);
  assign sq_full = mag * mag;

  assign sum_ext = {1'b0, sum_r[ch_idx]} + (SUM_W + 1)'(sq_r);
  assign sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  assign div_trial = {rem_r, quo_r[SUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, divisor_r});
  assign div_diff  = div_trial - {1'b0, divisor_r};

  assign root_in    = {rrem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign root_trial = (REM_W + 2)'({root_r, 2'b01});
  assign root_ge    = (root_in >= root_trial);
  assign root_diff  = root_in - root_trial;

  assign rms = (|root_r[ROOT_W-1:LEVEL_W]) ? LEVEL_MAX : root_r[LEVEL_W-1:0];

  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_inv = ALPHA_ONE - alpha_eff;
  assign level_sum = p_new_r + p_prev_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]    <= '0;
        count_r[i]  <= '0;
        ovf_r[i]    <= 1'b0;
        smooth_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        alpha_r <= cfg_data;
      end
      if (cmd.clear_all) begin
        for (int i = 0; i < CHANNELS; i++) begin
          sum_r[i]    <= '0;
          count_r[i]  <= '0;
          ovf_r[i]    <= 1'b0;
          smooth_r[i] <= '0;
        end
      end
      if (cmd.accum) begin
        if (count_r[ch_idx] < MAX_CNT) begin
          sum_r[ch_idx]   <= sum_new;
          count_r[ch_idx] <= count_r[ch_idx] + 1'b1;
        end else begin
          ovf_r[ch_idx] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        smooth_r[ch_idx] <= level_sum[2*LEVEL_W-1:LEVEL_W];
        sum_r[ch_idx]    <= '0;
        count_r[ch_idx]  <= '0;
        ovf_r[ch_idx]    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.square) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
    if (cmd.div_load) begin
      quo_r     <= sum_r[ch_idx];
      rem_r     <= '0;
      divisor_r <= count_r[ch_idx];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], div_ge};
      rem_r <= div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
    end
    if (cmd.root_load) begin
      rad_r  <= RAD_W'(quo_r[SUM_W-1:14]);
      rrem_r <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rrem_r <= root_ge ? root_diff[REM_W-1:0] : root_in[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], root_ge};
    end
    if (cmd.mul_new) begin
      p_new_r <= alpha_inv * rms;
    end
    if (cmd.mul_prev) begin
      p_prev_r <= alpha_eff * smooth_r[ch_idx];
    end
    if (cmd.finish) begin
      out_r.channel_res      <= in_r.channel;
      out_r.level            <= level_sum[2*LEVEL_W-1:LEVEL_W];
      out_r.block_overflowed <= ovf_r[ch_idx];
    end
  end

  assign out_data = out_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < divisor_r)
    else $error("divider remainder not below divisor");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum |=> (count_r[ch_idx] != '0 && count_r[ch_idx] <= MAX_CNT))
    else $error("sample count out of range after accumulate");

endmodule

// File: sv/block_rms_smoothed_meter.sv
// ----------------------------------------------------------------------------
// block_rms_smoothed_meter: per-channel block RMS meter with smoothing
// Squares and accumulates signed Q1.23 samples per channel; on the last
// sample of a block reports the exponentially smoothed RMS level in Q0.16.
// ----------------------------------------------------------------------------
// Sequencing: a sample request steps through accept, square and accumulate,
// a clear request through accept and clear. A sample marked last then passes
// the one-bit-per-cycle divider and the one-bit-per-cycle square root, each
// after its load, then two smoothing multiplies and the result hand-off; the
// result register lets the next request enter while a level still waits to
// be taken. The alpha register accepts a write every cycle.
module block_rms_smoothed_meter
  import brsm_pkg::*;
#(
  parameter int CHANNELS  = 2,
  parameter int MAX_BLOCK = 4096
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ALPHA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  brsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brsm_dp #(
    .CHANNELS  (CHANNELS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
